FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication whose consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/ipbn_pkg.sv
// Package for the inverse Park bus-normalized core: widths, CORDIC angle table.
// No dependencies.
`default_nettype none
package ipbn_pkg;
    localparam int GUARD_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int DW           = 52;   // CORDIC datapath width
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    // Arctangent of 2^-i as a fraction of a full turn (2^32).
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
                15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
                21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/ipbn_cordic_cell.sv
// One CORDIC rotation step; registered x, y, z and side data.
// Depends on ipbn_pkg.
`default_nettype none
module ipbn_cordic_cell #(
    parameter int STEP = 0,
    parameter int SW   = 49
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_vld,
    input  wire logic signed [ipbn_pkg::DW-1:0] x_in,
    input  wire logic signed [ipbn_pkg::DW-1:0] y_in,
    input  wire logic signed [32:0]            z_in,
    input  wire logic [SW-1:0]                 side_in,
    output logic                               out_vld,
    output logic signed [ipbn_pkg::DW-1:0]     x_out,
    output logic signed [ipbn_pkg::DW-1:0]     y_out,
    output logic signed [32:0]                 z_out,
    output logic [SW-1:0]                      side_out
);
    logic signed [ipbn_pkg::DW-1:0] x_next, y_next;
    logic signed [32:0] z_next, t;

    // Rotate toward zero residual angle
    always_comb
    begin
        t = $signed({1'b0, ipbn_pkg::atan_turn(STEP)});
        if (!z_in[32])
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - t;
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + t;
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (adv)
            out_vld <= in_vld;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            side_out <= side_in;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ipbn_div_cell.sv
// One restoring-division step for both axes; shifts a quotient bit in.
// Depends on ipbn_pkg.
`default_nettype none
module ipbn_div_cell #(
    parameter int MW = 53,
    parameter int QW = 15
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_vld,
    input  wire logic [MW-1:0]  den_in,
    input  wire logic [MW-1:0]  ma_in,
    input  wire logic [MW-1:0]  mb_in,
    input  wire logic [QW-1:0]  qa_in,
    input  wire logic [QW-1:0]  qb_in,
    input  wire logic [2:0]     flg_in,
    output logic                out_vld,
    output logic [MW-1:0]       den_out,
    output logic [MW-1:0]       ma_out,
    output logic [MW-1:0]       mb_out,
    output logic [QW-1:0]       qa_out,
    output logic [QW-1:0]       qb_out,
    output logic [2:0]          flg_out
);
    logic [MW:0] sa, sb;
    logic        ba, bb;

    // Trial subtract the shifted remainder
    always_comb
    begin
        sa = {ma_in, 1'b0};
        sb = {mb_in, 1'b0};
        ba = sa >= {1'b0, den_in};
        bb = sb >= {1'b0, den_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (adv)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_out <= den_in;
            ma_out  <= ba ? MW'(sa - {1'b0, den_in}) : sa[MW-1:0];
            mb_out  <= bb ? MW'(sb - {1'b0, den_in}) : sb[MW-1:0];
            qa_out  <= {qa_in[QW-2:0], ba};
            qb_out  <= {qb_in[QW-2:0], bb};
            flg_out <= flg_in;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/inverse_park_bus_normalized_core.sv
// Top level of the inverse Park transform with bus normalization.
// Depends on ipbn_pkg, ipbn_cordic_cell, ipbn_div_cell, assert_macros.svh.
`default_nettype none
// Accepts one command word per cycle while not stalled and returns one duty
// word per command, in order, through an input capture register, a gain
// multiply and quadrant fold register, 24 CORDIC cells, a magnitude and
// saturation prep register, one restoring-divider cell per duty fraction
// bit, and the output register. The whole row stalls together when the output
// is stalled while a word waits there.
module inverse_park_bus_normalized_core #(
    parameter int VOLT_BITS      = 16,
    parameter int ANGLE_BITS     = 16,
    parameter int DUTY_FRAC_BITS = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] d_voltage,
    input  wire logic [15:0] q_voltage,
    input  wire logic [15:0] elec_angle,
    input  wire logic [15:0] bus_voltage,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      alpha_duty,
    output logic [15:0]      beta_duty
);
    localparam int DW    = ipbn_pkg::DW;
    localparam int NS    = ipbn_pkg::CORDIC_STEPS;
    localparam int QW    = DUTY_FRAC_BITS + 1;
    localparam int MW    = VOLT_BITS + ipbn_pkg::GUARD_BITS + 2 + 20;
    localparam int SW    = VOLT_BITS + 1;

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Stage 0: capture inputs and left-align the angle
    logic                        s0_vld_reg;
    logic signed [VOLT_BITS-1:0] s0_d_reg, s0_q_reg;
    logic [31:0]                 s0_z_reg;
    logic [VOLT_BITS-1:0]        s0_bus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_d_reg   <= d_voltage[VOLT_BITS-1:0];
            s0_q_reg   <= q_voltage[VOLT_BITS-1:0];
            s0_z_reg   <= {elec_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
            s0_bus_reg <= bus_voltage[VOLT_BITS-1:0];
        end
    end

    // Stage 1: gain multiply, round, fold angle into +-pi/2
    logic signed [VOLT_BITS+32:0] pd, pq;
    logic signed [DW-1:0] gx, gy;
    logic                 fold;
    assign pd = $signed(s0_d_reg) * $signed({1'b0, ipbn_pkg::GAIN_Q30})
              + (VOLT_BITS+33)'(8192);
    assign pq = $signed(s0_q_reg) * $signed({1'b0, ipbn_pkg::GAIN_Q30})
              + (VOLT_BITS+33)'(8192);
    assign gx = DW'(pd >>> 14);
    assign gy = DW'(pq >>> 14);
    assign fold = ($signed(s0_z_reg) > $signed(32'h40000000))
               || ($signed(s0_z_reg) < $signed(32'hC0000000));

    logic                 s1_vld_reg;
    logic signed [DW-1:0] s1_x_reg, s1_y_reg;
    logic signed [32:0]   s1_z_reg;
    logic [SW-1:0]        s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= fold ? -gx : gx;
            s1_y_reg    <= fold ? -gy : gy;
            s1_z_reg    <= {(fold ? s0_z_reg[31] ^ 1'b1 : s0_z_reg[31]),
                            (fold ? s0_z_reg[31] ^ 1'b1 : s0_z_reg[31]),
                            s0_z_reg[30:0]};
            s1_side_reg <= {s0_bus_reg == '0, s0_bus_reg};
        end
    end

    // CORDIC chain
    logic                 c_vld [NS+1];
    logic signed [DW-1:0] c_x   [NS+1];
    logic signed [DW-1:0] c_y   [NS+1];
    logic signed [32:0]   c_z   [NS+1];
    logic [SW-1:0]        c_s   [NS+1];

    assign c_vld[0] = s1_vld_reg;
    assign c_x[0]   = s1_x_reg;
    assign c_y[0]   = s1_y_reg;
    assign c_z[0]   = s1_z_reg;
    assign c_s[0]   = s1_side_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        ipbn_cordic_cell #(.STEP(i), .SW(SW)) u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .in_vld(c_vld[i]), .x_in(c_x[i]), .y_in(c_y[i]), .z_in(c_z[i]),
            .side_in(c_s[i]),
            .out_vld(c_vld[i+1]), .x_out(c_x[i+1]), .y_out(c_y[i+1]),
            .z_out(c_z[i+1]), .side_out(c_s[i+1])
        );
    end

    // Divider prep: magnitudes, denominator, saturation flags
    logic [MW-1:0] den_w, ma_w, mb_w;
    logic          sat_a, sat_b;
    assign den_w = MW'({c_s[NS][VOLT_BITS-1:0], 16'h0000});
    assign ma_w  = MW'(c_x[NS][DW-1] ? -c_x[NS] : c_x[NS]);
    assign mb_w  = MW'(c_y[NS][DW-1] ? -c_y[NS] : c_y[NS]);
    assign sat_a = ma_w >= den_w;
    assign sat_b = mb_w >= den_w;

    logic          p_vld_reg;
    logic [MW-1:0] p_den_reg, p_ma_reg, p_mb_reg;
    logic [2:0]    p_flg_reg;
    logic [1:0]    p_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (adv)
            p_vld_reg <= c_vld[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_den_reg  <= den_w;
            p_ma_reg   <= sat_a ? '0 : ma_w;
            p_mb_reg   <= sat_b ? '0 : mb_w;
            p_sat_reg  <= {sat_b, sat_a};
            p_flg_reg  <= {c_s[NS][VOLT_BITS], c_y[NS][DW-1], c_x[NS][DW-1]};
        end
    end

    // Divider chain; saturation rides in the top quotient bits
    logic          v_vld [DUTY_FRAC_BITS+1];
    logic [MW-1:0] v_den [DUTY_FRAC_BITS+1];
    logic [MW-1:0] v_ma  [DUTY_FRAC_BITS+1];
    logic [MW-1:0] v_mb  [DUTY_FRAC_BITS+1];
    logic [QW-1:0] v_qa  [DUTY_FRAC_BITS+1];
    logic [QW-1:0] v_qb  [DUTY_FRAC_BITS+1];
    logic [2:0]    v_flg [DUTY_FRAC_BITS+1];

    // A saturated magnitude enters as zero, so its seed bit shifts up to 1.0
    assign v_vld[0] = p_vld_reg;
    assign v_den[0] = p_den_reg;
    assign v_ma[0]  = p_ma_reg;
    assign v_mb[0]  = p_mb_reg;
    assign v_qa[0]  = QW'(p_sat_reg[0]);
    assign v_qb[0]  = QW'(p_sat_reg[1]);
    assign v_flg[0] = p_flg_reg;

    for (genvar k = 0; k < DUTY_FRAC_BITS; k++)
    begin : g_div
        ipbn_div_cell #(.MW(MW), .QW(QW)) u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(v_vld[k]),
            .den_in(v_den[k]), .ma_in(v_ma[k]), .mb_in(v_mb[k]),
            .qa_in(v_qa[k]), .qb_in(v_qb[k]), .flg_in(v_flg[k]),
            .out_vld(v_vld[k+1]), .den_out(v_den[k+1]), .ma_out(v_ma[k+1]),
            .mb_out(v_mb[k+1]), .qa_out(v_qa[k+1]), .qb_out(v_qb[k+1]),
            .flg_out(v_flg[k+1])
        );
    end

    // Final: apply sign, zero bus
    logic [QW-1:0] fa, fb;
    logic [QW:0]   sa, sb;
    logic [2:0]    ff;
    assign ff = v_flg[DUTY_FRAC_BITS];
    assign fa = v_qa[DUTY_FRAC_BITS];
    assign fb = v_qb[DUTY_FRAC_BITS];
    assign sa = ff[0] ? -{1'b0, fa} : {1'b0, fa};
    assign sb = ff[1] ? -{1'b0, fb} : {1'b0, fb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v_vld[DUTY_FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha_duty <= ff[2] ? 16'h0 : 16'($signed(sa));
            beta_duty  <= ff[2] ? 16'h0 : 16'($signed(sb));
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_ties, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_IMPL(a_range, clk, rst_n, out_valid && DUTY_FRAC_BITS == 14,
        $signed(alpha_duty) <= 16384 && $signed(alpha_duty) >= -16384)
endmodule
`default_nettype wire
